// ===== src/nbb_pkg.sv =====
package nbb_pkg;

   // Table geometry
   localparam int NODE_COUNT = 64;
   localparam int IDX_W      = $clog2(NODE_COUNT);
   localparam int NODE_W     = 6;

   // Field widths
   localparam int RATE_W  = 24;
   localparam int LOAD_W  = 8;
   localparam int IDEAL_W = 16;
   localparam int CMD_W   = 2;

   localparam logic [RATE_W-1:0]  RATE_MASK = {RATE_W{1'b1}};
   localparam logic [IDEAL_W-1:0] LOAD_MAX  = {IDEAL_W{1'b1}};

   // Divider geometry
   localparam int DIV_W   = RATE_W;
   localparam int DCNT_W  = $clog2(DIV_W);
   localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DIV_W - 1);

   // Command codes
   localparam logic [CMD_W-1:0] CMD_WRITE      = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BOTTLENECK = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SORT_KEY   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_IDEAL      = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [NODE_W-1:0] node;
      logic [RATE_W-1:0] upload_bw;
      logic [RATE_W-1:0] download_bw;
      logic [LOAD_W-1:0] out_load;
      logic [LOAD_W-1:0] in_load;
      logic [RATE_W-1:0] limit_rate;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [RATE_W-1:0]  node_rate;
      logic               rate_unbounded;
      logic               limiting_port;
      logic [RATE_W-1:0]  global_rate;
      logic               global_unbounded;
      logic [IDEAL_W-1:0] ideal_out_load;
      logic [IDEAL_W-1:0] ideal_in_load;
      logic               load_saturated;
   } rsp_type;

   // One node entry
   typedef struct packed {
      logic [RATE_W-1:0] up;
      logic [RATE_W-1:0] dn;
   } entry_type;

   // Table access
   typedef struct packed {
      logic             wr_en;
      logic             rd_en;
      logic [IDX_W-1:0] addr;
      entry_type        wr_data;
   } tbl_cmd_type;

   // Divider control
   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   // Node field reduced modulo NODE_COUNT by shifted conditional subtracts
   function automatic logic [IDX_W-1:0] node_index(input logic [NODE_W-1:0] node);
      logic [IDX_W+NODE_W:0] r;
      logic [IDX_W+NODE_W:0] m;
      r = (IDX_W+NODE_W+1)'(node);
      for (int k = NODE_W - 1; k >= 0; k--) begin
         m = (IDX_W+NODE_W+1)'(NODE_COUNT) << k;
         if (r >= m) begin
            r = r - m;
         end
      end
      return r[IDX_W-1:0];
   endfunction

endpackage

// ===== src/node_bandwidth_bottleneck.sv =====
// Node bandwidth bottleneck evaluator.
// Request channel (req_valid/req_ready/req_data) carries one command:
//   write entry, bottleneck, sort key or ideal load. Each request yields
//   exactly one response on rsp_valid/rsp_ready/rsp_data.
// A write entry request goes straight to the finishing step. The other
// commands read the node entry, then run two 24-bit divisions, one bit per
// cycle, on a single shared restoring divider (upload side, then download
// side). The response is registered as the sequencer returns to idle, so a
// next request can be taken in the same cycle as the response appears. A
// new request is taken only once the last one is through its finishing step.
// The response register decouples the sides: a new request is taken while
// an earlier response still waits; a request finishes only once that
// register is free, so a stalled receiver holds the block in its last step.
// Reset clears control state and the running minimum (unbounded, all ones).
// The node table has no reset; reading an entry never written gives an
// arbitrary value.
module node_bandwidth_bottleneck (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  nbb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output nbb_pkg::rsp_type rsp_data
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_READ   = 5'b00010,
      ST_DIV_UP = 5'b00100,
      ST_DIV_DN = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type                  state_ff, state_in;
   nbb_pkg::req_type           req_ff, req_in;
   logic [nbb_pkg::RATE_W-1:0] q_up_ff, q_up_in;
   logic [nbb_pkg::RATE_W-1:0] q_dn_ff, q_dn_in;
   logic [nbb_pkg::RATE_W-1:0] min_ff, min_in;
   logic                       min_unb_ff, min_unb_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   nbb_pkg::rsp_type           rsp_ff, rsp_in;

   nbb_pkg::tbl_cmd_type       tbl_cmd;
   nbb_pkg::entry_type         entry;
   nbb_pkg::div_req_type       div_req;
   nbb_pkg::div_rsp_type       div_rsp;

   logic                       accept;
   logic                       out_free;
   logic                       finish;

   // Result terms
   logic                       is_key;
   logic                       uu, du;
   logic [nbb_pkg::RATE_W-1:0] up_rate, dn_rate;
   logic                       up_less;
   logic [nbb_pkg::RATE_W-1:0] sel_rate;
   logic                       sel_port;
   logic                       both_unb;
   logic                       lim_zero;
   logic                       sat_up, sat_dn;
   logic [nbb_pkg::RATE_W-1:0] fold_min;
   logic                       fold_unb;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign finish    = (state_ff == ST_FINISH) && out_free;

   // Node table access at request acceptance
   always_comb begin
      tbl_cmd.wr_en      = accept && (req_data.command == nbb_pkg::CMD_WRITE);
      tbl_cmd.rd_en      = accept && (req_data.command != nbb_pkg::CMD_WRITE);
      tbl_cmd.addr       = nbb_pkg::node_index(req_data.node);
      tbl_cmd.wr_data.up = req_data.upload_bw;
      tbl_cmd.wr_data.dn = req_data.download_bw;
   end

   nbb_table u_tbl (
      .clock   (clock),
      .cmd     (tbl_cmd),
      .rd_data (entry)
   );

   // Shared divider: upload side started from READ, download side on its done
   always_comb begin
      div_req.start    = (state_ff == ST_READ) || ((state_ff == ST_DIV_UP) && div_rsp.done);
      div_req.dividend = (state_ff == ST_READ) ? entry.up : entry.dn;
      if (req_ff.command == nbb_pkg::CMD_IDEAL) begin
         div_req.divisor = req_ff.limit_rate;
      end else if (state_ff == ST_READ) begin
         div_req.divisor = nbb_pkg::DIV_W'(req_ff.out_load);
      end else begin
         div_req.divisor = nbb_pkg::DIV_W'(req_ff.in_load);
      end
   end

   nbb_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Sequencer
   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      q_up_in  = q_up_ff;
      q_dn_in  = q_dn_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               state_in = (req_data.command == nbb_pkg::CMD_WRITE) ? ST_FINISH : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_DIV_UP;
         end
         ST_DIV_UP: begin
            if (div_rsp.done) begin
               q_up_in  = div_rsp.quotient;
               state_in = ST_DIV_DN;
            end
         end
         ST_DIV_DN: begin
            if (div_rsp.done) begin
               q_dn_in  = div_rsp.quotient;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Per-port rates and port choice
   always_comb begin
      is_key   = (req_ff.command == nbb_pkg::CMD_SORT_KEY);
      uu       = (req_ff.out_load == '0) && !is_key;
      du       = (req_ff.in_load == '0) && !is_key;
      if (req_ff.out_load == '0) begin
         up_rate = is_key ? entry.up : nbb_pkg::RATE_MASK;
      end else begin
         up_rate = q_up_ff;
      end
      if (req_ff.in_load == '0) begin
         dn_rate = is_key ? entry.dn : nbb_pkg::RATE_MASK;
      end else begin
         dn_rate = q_dn_ff;
      end
      up_less  = (!uu && du) || (!uu && !du && (up_rate < dn_rate));
      both_unb = uu && du;
      sel_port = !up_less;
      if (both_unb) begin
         sel_rate = nbb_pkg::RATE_MASK;
      end else begin
         sel_rate = up_less ? up_rate : dn_rate;
      end
   end

   // Ideal load saturation
   always_comb begin
      lim_zero = (req_ff.limit_rate == '0);
      sat_up   = lim_zero || (q_up_ff[nbb_pkg::RATE_W-1:nbb_pkg::IDEAL_W] != '0);
      sat_dn   = lim_zero || (q_dn_ff[nbb_pkg::RATE_W-1:nbb_pkg::IDEAL_W] != '0);
   end

   // Global minimum fold, bottleneck command only
   always_comb begin
      fold_min = min_ff;
      fold_unb = min_unb_ff;
      if ((req_ff.command == nbb_pkg::CMD_BOTTLENECK) && !both_unb) begin
         if (min_unb_ff || (sel_rate < min_ff)) begin
            fold_min = sel_rate;
            fold_unb = 1'b0;
         end
      end
   end

   // Response assembly and running minimum update
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      min_in       = min_ff;
      min_unb_in   = min_unb_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in            = 1'b1;
         rsp_in                  = '0;
         rsp_in.global_rate      = fold_min;
         rsp_in.global_unbounded = fold_unb;
         unique case (req_ff.command) inside
            nbb_pkg::CMD_BOTTLENECK, nbb_pkg::CMD_SORT_KEY: begin
               rsp_in.node_rate      = sel_rate;
               rsp_in.limiting_port  = sel_port;
               rsp_in.rate_unbounded = both_unb && !is_key;
            end
            nbb_pkg::CMD_IDEAL: begin
               rsp_in.ideal_out_load = sat_up ? nbb_pkg::LOAD_MAX
                                              : q_up_ff[nbb_pkg::IDEAL_W-1:0];
               rsp_in.ideal_in_load  = sat_dn ? nbb_pkg::LOAD_MAX
                                              : q_dn_ff[nbb_pkg::IDEAL_W-1:0];
               rsp_in.load_saturated = sat_up || sat_dn;
            end
            default: begin
               rsp_in.node_rate = '0;
            end
         endcase
         if (req_ff.last) begin
            min_in     = nbb_pkg::RATE_MASK;
            min_unb_in = 1'b1;
         end else begin
            min_in     = fold_min;
            min_unb_in = fold_unb;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         min_ff       <= nbb_pkg::RATE_MASK;
         min_unb_ff   <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         min_ff       <= min_in;
         min_unb_ff   <= min_unb_in;
      end
      req_ff  <= req_in;
      q_up_ff <= q_up_in;
      q_dn_ff <= q_dn_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   // A response appears only out of the finishing step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside finishing step");

   // An accepted request always leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("request accepted but sequencer stayed idle");

   // Unbounded running minimum keeps the all-ones value
   a_min_unb: assert property (@(posedge clock) disable iff (reset)
      min_unb_ff |-> (min_ff == nbb_pkg::RATE_MASK))
      else $error("unbounded running minimum lost its all-ones value");

   // An unbounded node rate is reported as all ones
   a_rate_unb: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.rate_unbounded) |-> (rsp_ff.node_rate == nbb_pkg::RATE_MASK))
      else $error("unbounded rate not all ones");
`endif

endmodule

// ===== src/nbb_table.sv =====
module nbb_table (
   input  logic                  clock,
   input  nbb_pkg::tbl_cmd_type  cmd,
   output nbb_pkg::entry_type    rd_data
);

   nbb_pkg::entry_type mem [nbb_pkg::NODE_COUNT];
   nbb_pkg::entry_type rd_data_ff;

   // Single port: write or registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/nbb_div.sv =====
module nbb_div (
   input  logic                 clock,
   input  logic                 reset,
   input  nbb_pkg::div_req_type req,
   output nbb_pkg::div_rsp_type rsp
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [nbb_pkg::DCNT_W-1:0]  count_ff, count_in;
   logic [nbb_pkg::DIV_W-1:0]   rem_ff, rem_in;
   logic [nbb_pkg::DIV_W-1:0]   quo_ff, quo_in;
   logic [nbb_pkg::DIV_W-1:0]   divisor_ff, divisor_in;
   logic [nbb_pkg::DIV_W:0]     shifted;
   logic [nbb_pkg::DIV_W+1:0]   diff;
   logic                        ge;

   // One restoring step: bring down the next dividend bit, trial subtract
   always_comb begin
      shifted = {rem_ff, quo_ff[nbb_pkg::DIV_W-1]};
      diff    = {1'b0, shifted} - {2'b00, divisor_ff};
      ge      = ~diff[nbb_pkg::DIV_W+1];
   end

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (busy_ff) begin
         rem_in   = ge ? diff[nbb_pkg::DIV_W-1:0] : shifted[nbb_pkg::DIV_W-1:0];
         quo_in   = {quo_ff[nbb_pkg::DIV_W-2:0], ge};
         count_in = count_ff + 1'b1;
         if (count_ff == nbb_pkg::DCNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         quo_in     = req.dividend;
         divisor_in = req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule
